// ===== rtl/ddep_pkg.sv =====
// Shared types and constants for the differential drive encoder PID block.
package ddep_pkg;

    localparam int GAIN_BITS      = 16;
    localparam int SUM_BITS       = 32;
    localparam int CFG_DUTY_BITS  = 10;
    localparam int TARGET_BITS    = 20;
    localparam int MODE_BITS      = 2;
    localparam int FRAC_BITS      = 8;
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_KP_GAIN          = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KD_GAIN          = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KI_GAIN          = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_DUTY        = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_DUTY        = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_COUNT     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE_MODE       = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTEGRATE_ENABLE = 3'd7;

    localparam logic [MODE_BITS-1:0] MODE_STRAIGHT = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_RIGHT    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_LEFT     = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_START  = 1'b1;

    localparam logic [GAIN_BITS-1:0]     RST_KP_GAIN          = 16'd2560;
    localparam logic [GAIN_BITS-1:0]     RST_KD_GAIN          = 16'd0;
    localparam logic [GAIN_BITS-1:0]     RST_KI_GAIN          = 16'd0;
    localparam logic [CFG_DUTY_BITS-1:0] RST_BASE_DUTY        = 10'd512;
    localparam logic [CFG_DUTY_BITS-1:0] RST_STOP_DUTY        = 10'd1023;
    localparam logic [TARGET_BITS-1:0]   RST_TARGET_COUNT     = 20'd0;
    localparam logic [MODE_BITS-1:0]     RST_DRIVE_MODE       = MODE_STRAIGHT;
    localparam logic                     RST_INTEGRATE_ENABLE = 1'b1;

    typedef struct packed {
        logic [GAIN_BITS-1:0]     kp_gain;
        logic [GAIN_BITS-1:0]     kd_gain;
        logic [GAIN_BITS-1:0]     ki_gain;
        logic [CFG_DUTY_BITS-1:0] base_duty;
        logic [CFG_DUTY_BITS-1:0] stop_duty;
        logic [TARGET_BITS-1:0]   target_count;
        logic [MODE_BITS-1:0]     drive_mode;
        logic                     integrate_enable;
    } cfg_t;

    typedef struct packed {
        logic stopped;
        logic finished;
    } pid_status_t;

endpackage

// ===== rtl/ddep_if.sv =====
// Valid/ready channel interfaces for encoder samples and bridge duty results.
interface ddep_in_if #(
    parameter int COUNT_BITS = 20
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COUNT_BITS-1:0] left_count;
    logic [COUNT_BITS-1:0] right_count;

    modport source (output valid, output op, output left_count, output right_count,
                    input ready);
    modport sink   (input valid, input op, input left_count, input right_count,
                    output ready);
endinterface

interface ddep_out_if #(
    parameter int DUTY_BITS = 10
);
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] m1_in1_duty;
    logic [DUTY_BITS-1:0] m1_in2_duty;
    logic [DUTY_BITS-1:0] m2_in1_duty;
    logic [DUTY_BITS-1:0] m2_in2_duty;
    logic                 move_finished;

    modport source (output valid, output m1_in1_duty, output m1_in2_duty,
                    output m2_in1_duty, output m2_in2_duty, output move_finished,
                    input ready);
    modport sink   (input valid, input m1_in1_duty, input m1_in2_duty,
                    input m2_in1_duty, input m2_in2_duty, input move_finished,
                    output ready);
endinterface

// ===== rtl/ddep_cfg_regs.sv =====
// Configuration register file written through a plain write port.
module ddep_cfg_regs
    import ddep_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain          <= RST_KP_GAIN;
            cfg_reg.kd_gain          <= RST_KD_GAIN;
            cfg_reg.ki_gain          <= RST_KI_GAIN;
            cfg_reg.base_duty        <= RST_BASE_DUTY;
            cfg_reg.stop_duty        <= RST_STOP_DUTY;
            cfg_reg.target_count     <= RST_TARGET_COUNT;
            cfg_reg.drive_mode       <= RST_DRIVE_MODE;
            cfg_reg.integrate_enable <= RST_INTEGRATE_ENABLE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KP_GAIN:          cfg_reg.kp_gain <= cfg_data[GAIN_BITS-1:0];
                REG_KD_GAIN:          cfg_reg.kd_gain <= cfg_data[GAIN_BITS-1:0];
                REG_KI_GAIN:          cfg_reg.ki_gain <= cfg_data[GAIN_BITS-1:0];
                REG_BASE_DUTY:        cfg_reg.base_duty <= cfg_data[CFG_DUTY_BITS-1:0];
                REG_STOP_DUTY:        cfg_reg.stop_duty <= cfg_data[CFG_DUTY_BITS-1:0];
                REG_TARGET_COUNT:     cfg_reg.target_count <= cfg_data[TARGET_BITS-1:0];
                REG_DRIVE_MODE:       cfg_reg.drive_mode <= cfg_data[MODE_BITS-1:0];
                REG_INTEGRATE_ENABLE: cfg_reg.integrate_enable <= cfg_data[0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ddep_pid.sv =====
// PID correction, duty saturation, bridge direction and move state registers.
module ddep_pid
    import ddep_pkg::*;
#(
    parameter int COUNT_BITS = 20,
    parameter int DUTY_BITS  = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  step,
    input  logic                  op,
    input  logic [COUNT_BITS-1:0] left_count,
    input  logic [COUNT_BITS-1:0] right_count,
    output logic [DUTY_BITS-1:0]  m1_in1_duty,
    output logic [DUTY_BITS-1:0]  m1_in2_duty,
    output logic [DUTY_BITS-1:0]  m2_in1_duty,
    output logic [DUTY_BITS-1:0]  m2_in2_duty,
    output logic                  move_finished,
    output pid_status_t           status
);

    localparam int EW   = COUNT_BITS + 1;
    localparam int DW   = COUNT_BITS + 2;
    localparam int GW   = GAIN_BITS + 1;
    localparam int PW   = GW + DW;
    localparam int IW   = GW + SUM_BITS;
    localparam int W    = ((PW > IW) ? PW : IW) + 2;
    localparam int SW   = ((SUM_BITS > EW) ? SUM_BITS : EW) + 1;
    localparam int CW   = (DUTY_BITS < CFG_DUTY_BITS) ? DUTY_BITS : CFG_DUTY_BITS;
    localparam int CMPW = (COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS;

    localparam logic signed [W-1:0] ROUND_BIAS =
        {{(W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    localparam logic signed [W:0] DUTY_MAX =
        {{(W+1-DUTY_BITS){1'b0}}, {DUTY_BITS{1'b1}}};
    localparam logic signed [SW-1:0] SUM_MAX =
        {{(SW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN =
        {{(SW-SUM_BITS+1){1'b1}}, {(SUM_BITS-1){1'b0}}};

    logic signed [EW-1:0]       prev_error_reg;
    logic signed [EW-1:0]       prev_error_next;
    logic signed [SUM_BITS-1:0] error_sum_reg;
    logic signed [SUM_BITS-1:0] error_sum_next;
    logic                       stopped_reg;
    logic                       stopped_next;

    logic signed [EW-1:0]       err;
    logic signed [DW-1:0]       delta;
    logic signed [SUM_BITS-1:0] sum_used;
    logic signed [GW-1:0]       kp_s;
    logic signed [GW-1:0]       kd_s;
    logic signed [GW-1:0]       ki_s;
    logic signed [PW-1:0]       p_prod;
    logic signed [PW-1:0]       d_prod;
    logic signed [IW-1:0]       i_prod;
    logic signed [W-1:0]        total;
    logic signed [W-1:0]        biased;
    logic signed [W-1:0]        pid;
    logic signed [W:0]          base_w;
    logic signed [W:0]          raw1;
    logic signed [W:0]          raw2;
    logic [DUTY_BITS-1:0]       duty1;
    logic [DUTY_BITS-1:0]       duty2;
    logic [DUTY_BITS-1:0]       stop_d;
    logic signed [SW-1:0]       acc;
    logic signed [SW-1:0]       acc_sat;
    logic                       m1_fwd;
    logic                       m2_fwd;
    logic                       reach;

    function automatic logic [DUTY_BITS-1:0] clamp_duty(input logic signed [W:0] v);
        logic [DUTY_BITS-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > DUTY_MAX)
            r = {DUTY_BITS{1'b1}};
        else
            r = v[DUTY_BITS-1:0];
        return r;
    endfunction

    always_comb
    begin
        err      = $signed({1'b0, left_count}) - $signed({1'b0, right_count});
        delta    = DW'(err) - DW'(prev_error_reg);
        sum_used = cfg.integrate_enable ? error_sum_reg : '0;
        kp_s     = $signed({1'b0, cfg.kp_gain});
        kd_s     = $signed({1'b0, cfg.kd_gain});
        ki_s     = $signed({1'b0, cfg.ki_gain});
        p_prod   = PW'(kp_s) * PW'(err);
        d_prod   = PW'(kd_s) * PW'(delta);
        i_prod   = IW'(ki_s) * IW'(sum_used);
        total    = W'(p_prod) + W'(d_prod) + W'(i_prod);
        biased   = total[W-1] ? (total + ROUND_BIAS) : total;
        pid      = biased >>> FRAC_BITS;
        base_w   = $signed({{(W+1-CW){1'b0}}, cfg.base_duty[CW-1:0]});
        raw1     = base_w - (W+1)'(pid);
        raw2     = base_w + (W+1)'(pid);
        duty1    = clamp_duty(raw1);
        duty2    = clamp_duty(raw2);
        stop_d   = DUTY_BITS'(cfg.stop_duty[CW-1:0]);

        acc = SW'(error_sum_reg) + SW'(err);
        if (acc > SUM_MAX)
            acc_sat = SUM_MAX;
        else if (acc < SUM_MIN)
            acc_sat = SUM_MIN;
        else
            acc_sat = acc;

        m1_fwd = (cfg.drive_mode != MODE_LEFT);
        m2_fwd = (cfg.drive_mode != MODE_RIGHT);
        reach  = (cfg.target_count != '0)
                 && (CMPW'(left_count) >= CMPW'(cfg.target_count));

        prev_error_next = prev_error_reg;
        error_sum_next  = error_sum_reg;
        stopped_next    = stopped_reg;

        if (op == OP_START)
        begin
            m1_in1_duty     = '0;
            m1_in2_duty     = '0;
            m2_in1_duty     = '0;
            m2_in2_duty     = '0;
            move_finished   = 1'b0;
            prev_error_next = '0;
            error_sum_next  = '0;
            stopped_next    = 1'b0;
        end
        else if (stopped_reg)
        begin
            m1_in1_duty   = stop_d;
            m1_in2_duty   = stop_d;
            m2_in1_duty   = stop_d;
            m2_in2_duty   = stop_d;
            move_finished = 1'b1;
        end
        else
        begin
            m1_in1_duty     = m1_fwd ? '0 : duty1;
            m1_in2_duty     = m1_fwd ? duty1 : '0;
            m2_in1_duty     = m2_fwd ? '0 : duty2;
            m2_in2_duty     = m2_fwd ? duty2 : '0;
            move_finished   = reach;
            prev_error_next = err;
            error_sum_next  = cfg.integrate_enable ? SUM_BITS'(acc_sat) : '0;
            stopped_next    = reach;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg <= '0;
            error_sum_reg  <= '0;
            stopped_reg    <= 1'b0;
        end
        else if (step)
        begin
            prev_error_reg <= prev_error_next;
            error_sum_reg  <= error_sum_next;
            stopped_reg    <= stopped_next;
        end
    end

    assign status.stopped  = stopped_reg;
    assign status.finished = move_finished;

endmodule

// ===== rtl/diff_drive_encoder_pid.sv =====
// Top level of the differential drive encoder PID wheel synchronizer.
//
//  Port     Direction  Transfer content
//  sample   sink       op, left_count, right_count
//  result   source     four bridge duties and move_finished
//  cfg_*    write      register index and data, one write per cycle
//
// A sample is held in an input register and its result is computed combinationally
// into the result register, which loads when it is empty or its result is taken;
// one sample can be taken every cycle while the result side does not stall.
// Reset loads the register defaults and clears the error state and stop flag.
// A stalled result holds the result register and a full input register; the input register
// empties into the result register in the same cycle that the result is taken.
module diff_drive_encoder_pid
    import ddep_pkg::*;
#(
    parameter int COUNT_BITS = 20,
    parameter int DUTY_BITS  = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    ddep_in_if.sink                   sample,
    ddep_out_if.source                result
);

    cfg_t                  cfg;
    pid_status_t           status;

    logic                  in_valid_reg;
    logic                  in_op_reg;
    logic [COUNT_BITS-1:0] in_left_reg;
    logic [COUNT_BITS-1:0] in_right_reg;

    logic                  out_valid_reg;
    logic [DUTY_BITS-1:0]  m1_in1_reg;
    logic [DUTY_BITS-1:0]  m1_in2_reg;
    logic [DUTY_BITS-1:0]  m2_in1_reg;
    logic [DUTY_BITS-1:0]  m2_in2_reg;
    logic                  finished_reg;

    logic [DUTY_BITS-1:0]  m1_in1_next;
    logic [DUTY_BITS-1:0]  m1_in2_next;
    logic [DUTY_BITS-1:0]  m2_in1_next;
    logic [DUTY_BITS-1:0]  m2_in2_next;
    logic                  finished_next;

    logic                  advance;
    logic                  in_fire;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign in_fire      = sample.valid && sample.ready;

    ddep_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ddep_pid #(
        .COUNT_BITS (COUNT_BITS),
        .DUTY_BITS  (DUTY_BITS)
    ) u_pid
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .step          (advance),
        .op            (in_op_reg),
        .left_count    (in_left_reg),
        .right_count   (in_right_reg),
        .m1_in1_duty   (m1_in1_next),
        .m1_in2_duty   (m1_in2_next),
        .m2_in1_duty   (m2_in1_next),
        .m2_in2_duty   (m2_in2_next),
        .move_finished (finished_next),
        .status        (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_op_reg    <= sample.op;
            in_left_reg  <= sample.left_count;
            in_right_reg <= sample.right_count;
        end
        if (advance)
        begin
            m1_in1_reg   <= m1_in1_next;
            m1_in2_reg   <= m1_in2_next;
            m2_in1_reg   <= m2_in1_next;
            m2_in2_reg   <= m2_in2_next;
            finished_reg <= finished_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.m1_in1_duty   = m1_in1_reg;
    assign result.m1_in2_duty   = m1_in2_reg;
    assign result.m2_in1_duty   = m2_in1_reg;
    assign result.m2_in2_duty   = m2_in2_reg;
    assign result.move_finished = finished_reg;

    // A held sample that cannot move on keeps its place and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_left_reg)
                                        && $stable(in_op_reg)))
        else $error("input register lost a stalled sample");

    // A finishing sample leaves the move stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_op_reg == OP_SAMPLE) && status.finished) |=> status.stopped)
        else $error("finishing sample did not stop the move");

    // A start command always clears the stop flag and the registered finished flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_op_reg == OP_START)) |=> (!status.stopped && !finished_reg))
        else $error("start command did not clear the move state");

    // The sample side only stalls while the input register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> in_valid_reg)
        else $error("sample side stalled with an empty input register");

endmodule
